@@ rtl/rvc_pkg.sv @@
// Shared constants and types for the RV32I subset execution core.
// No dependencies; used by the interfaces, the core and its checker.
`default_nettype none

package rvc_pkg;

  localparam int unsigned XLEN           = 32;
  localparam int unsigned REG_W          = 5;
  localparam int unsigned DEF_DATA_BYTES = 4096;

  localparam logic [6:0] OP_R     = 7'h33;
  localparam logic [6:0] OP_I     = 7'h13;
  localparam logic [6:0] OP_LOAD  = 7'h03;
  localparam logic [6:0] OP_STORE = 7'h23;
  localparam logic [6:0] OP_JAL   = 7'h6F;
  localparam logic [6:0] OP_BR    = 7'h63;
  localparam logic [6:0] OP_LUI   = 7'h37;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRAI = 3'd5;
  localparam logic [2:0] F3_ORI  = 3'd6;
  localparam logic [2:0] F3_BYTE = 3'd0;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [6:0] F7_BASE = 7'h00;

  localparam logic [XLEN-1:0] LUI_MASK = 32'hFFFF_F000;

  typedef enum logic [1:0] {
    ST_EXEC    = 2'd0,
    ST_END     = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LD_NONE = 2'd0,
    LD_BYTE = 2'd1,
    LD_WORD = 2'd2
  } load_e;

endpackage

`default_nettype wire

@@ rtl/rvc_if.sv @@
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on rvc_pkg for field widths.
`default_nettype none

interface rvc_in_if;
  logic                      valid;
  logic                      ready;
  logic [rvc_pkg::XLEN-1:0]  instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rvc_pkg::XLEN-1:0]  next_pc;
  logic                      branch_taken;
  logic                      writes_register;
  logic [rvc_pkg::REG_W-1:0] dest_register;
  logic [rvc_pkg::XLEN-1:0]  write_value;
  logic [1:0]                status;

  modport source (output valid, output next_pc, output branch_taken,
                  output writes_register, output dest_register,
                  output write_value, output status, input ready);
  modport sink   (input valid, input next_pc, input branch_taken,
                  input writes_register, input dest_register,
                  input write_value, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/rv32i_subset_core_step.sv @@
// RV32I subset core step: register file, four byte-wide data banks; needs rvc_pkg, rvc_if.
// A result beat follows its instruction beat through the EX register (registered register
// file read) and then the result register, where it waits until it is taken.
// Throughput: one instruction per cycle while results drain; forwarding from the result
// register covers the registered reads. Reset (async, low): PC and register valid bits clear
// at once, then the data banks are swept to zero, with in_i.ready low.
`default_nettype none

module rv32i_subset_core_step import rvc_pkg::*; #(
  parameter int unsigned DATA_BYTES = DEF_DATA_BYTES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rvc_in_if.sink     in_i,
  rvc_out_if.source  out_o
);

  localparam int unsigned NBANK  = 4;
  localparam int unsigned ADDR_W = $clog2(DATA_BYTES);
  localparam int unsigned ROW_W  = ADDR_W - 2;
  localparam int unsigned ROWS   = DATA_BYTES / NBANK;

  // handshakes
  logic in_acc, ex_adv, out_acc;

  // clearing sweep of the data banks
  logic             clr_busy_q;
  logic [ROW_W-1:0] clr_row_q;

  // EX stage
  logic            ex_valid_q;
  logic [XLEN-1:0] ex_instr_q;
  logic [XLEN-1:0] pc_q;

  // register file
  logic [XLEN-1:0] rf_mem [32];
  logic [31:0]     rf_vld_q;
  logic [XLEN-1:0] rs1_data_q, rs2_data_q, byp_data_q;
  logic            rs1_ok_q, rs2_ok_q, rs1_byp_q, rs2_byp_q;
  logic            rf_we;
  logic [REG_W-1:0] in_rs1, in_rs2;
  logic [XLEN-1:0] rf_a, rf_b;

  // WB / result register
  logic             wb_valid_q;
  logic [XLEN-1:0]  wb_npc_q, wb_alu_q;
  logic             wb_taken_q, wb_wr_q;
  logic [REG_W-1:0] wb_rd_q;
  status_e          wb_status_q;
  load_e            wb_load_q;
  logic [1:0]       wb_off_q;
  logic [XLEN-1:0]  wb_value;

  // EX decode
  logic [6:0]       opc, f7;
  logic [2:0]       f3;
  logic [REG_W-1:0] ex_rs1, ex_rs2, rd;
  logic [XLEN-1:0]  a, b, imm_i, imm_s, imm_b, imm_j, ea;
  logic [XLEN-1:0]  ex_npc, ex_val;
  logic             ex_taken, ex_wr, st_byte, st_word;
  logic [REG_W-1:0] ex_rd;
  status_e          ex_status;
  load_e            ex_load;
  logic [1:0]       ea_off;
  logic [ROW_W-1:0] ea_row;

  logic [7:0] dm_rdata [NBANK];

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign ex_adv  = ex_valid_q && (!wb_valid_q || out_o.ready);

  assign in_i.ready = !clr_busy_q && (!ex_valid_q || ex_adv);

  // ---------------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
      ex_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
      pc_q       <= '0;
      rf_vld_q   <= '0;
      rs1_ok_q   <= 1'b0;
      rs2_ok_q   <= 1'b0;
      rs1_byp_q  <= 1'b0;
      rs2_byp_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + ROW_W'(1);
        if (clr_row_q == ROW_W'(ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_acc) begin
        ex_valid_q <= 1'b1;
      end else if (ex_adv) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_adv) begin
        wb_valid_q <= 1'b1;
        pc_q       <= ex_npc;
      end else if (out_acc) begin
        wb_valid_q <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_q[wb_rd_q] <= 1'b1;
      end
      if (in_acc) begin
        rs1_ok_q  <= rf_vld_q[in_rs1];
        rs2_ok_q  <= rf_vld_q[in_rs2];
        // a write landing on the same edge is not seen by the array read
        rs1_byp_q <= rf_we && (wb_rd_q == in_rs1);
        rs2_byp_q <= rf_we && (wb_rd_q == in_rs2);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // register file: one write port, two read ports, registered read data
  assign in_rs1 = in_i.instruction_word[19:15];
  assign in_rs2 = in_i.instruction_word[24:20];
  assign rf_we  = out_acc && wb_wr_q;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[wb_rd_q] <= wb_value;
    end
    if (in_acc) begin
      rs1_data_q <= rf_mem[in_rs1];
      rs2_data_q <= rf_mem[in_rs2];
      byp_data_q <= wb_value;
      ex_instr_q <= in_i.instruction_word;
    end
  end

  assign rf_a = rs1_byp_q ? byp_data_q : (rs1_ok_q ? rs1_data_q : '0);
  assign rf_b = rs2_byp_q ? byp_data_q : (rs2_ok_q ? rs2_data_q : '0);

  // ---------------------------------------------------------------------------
  // EX: decode, forward from the result register, execute
  assign opc    = ex_instr_q[6:0];
  assign rd     = ex_instr_q[11:7];
  assign f3     = ex_instr_q[14:12];
  assign ex_rs1 = ex_instr_q[19:15];
  assign ex_rs2 = ex_instr_q[24:20];
  assign f7     = ex_instr_q[31:25];

  assign a = (wb_valid_q && wb_wr_q && (wb_rd_q == ex_rs1)) ? wb_value : rf_a;
  assign b = (wb_valid_q && wb_wr_q && (wb_rd_q == ex_rs2)) ? wb_value : rf_b;

  assign imm_i = {{20{ex_instr_q[31]}}, ex_instr_q[31:20]};
  assign imm_s = {{20{ex_instr_q[31]}}, ex_instr_q[31:25], ex_instr_q[11:7]};
  assign imm_b = {{19{ex_instr_q[31]}}, ex_instr_q[31], ex_instr_q[7],
                  ex_instr_q[30:25], ex_instr_q[11:8], 1'b0};
  assign imm_j = {{11{ex_instr_q[31]}}, ex_instr_q[31], ex_instr_q[19:12],
                  ex_instr_q[20], ex_instr_q[30:21], 1'b0};

  assign ea     = a + ((opc == OP_STORE) ? imm_s : imm_i);
  assign ea_off = ea[1:0];
  assign ea_row = ea[ADDR_W-1:2];

  always_comb begin
    ex_npc    = pc_q + XLEN'(4);
    ex_taken  = 1'b0;
    ex_wr     = 1'b0;
    ex_val    = '0;
    ex_status = ST_EXEC;
    ex_load   = LD_NONE;
    st_byte   = 1'b0;
    st_word   = 1'b0;
    ex_rd     = rd;
    if (ex_instr_q == '0) begin
      ex_status = ST_END;
      ex_npc    = pc_q;
    end else begin
      unique case (opc)
        OP_R: begin
          if (f7 == F7_BASE && f3 == F3_ADD) begin
            ex_val = a + b;
            ex_wr  = 1'b1;
          end else if (f7 == F7_BASE && f3 == F3_XOR) begin
            ex_val = a ^ b;
            ex_wr  = 1'b1;
          end
        end
        OP_I: begin
          if (f3 == F3_ADD) begin
            ex_val = a + imm_i;
            ex_wr  = 1'b1;
          end else if (f3 == F3_ORI) begin
            ex_val = a | imm_i;
            ex_wr  = 1'b1;
          end else if (f3 == F3_SRAI) begin
            ex_val = XLEN'($signed(a) >>> ex_instr_q[24:20]);
            ex_wr  = 1'b1;
          end
        end
        OP_LOAD: begin
          if (f3 == F3_BYTE) begin
            ex_load = LD_BYTE;
            ex_wr   = 1'b1;
          end else if (f3 == F3_WORD) begin
            ex_load = LD_WORD;
            ex_wr   = 1'b1;
          end
        end
        OP_STORE: begin
          st_byte = (f3 == F3_BYTE);
          st_word = (f3 == F3_WORD);
        end
        OP_BR: begin
          if (f3 == F3_BEQ && a == b) begin
            ex_npc   = pc_q + imm_b;
            ex_taken = 1'b1;
          end
        end
        OP_JAL: begin
          ex_val   = pc_q + XLEN'(4);
          ex_wr    = 1'b1;
          ex_npc   = pc_q + imm_j;
          ex_taken = 1'b1;
        end
        OP_LUI: begin
          ex_val = ex_instr_q & LUI_MASK;
          ex_wr  = 1'b1;
        end
        default: begin
          ex_status = ST_ILLEGAL;
          ex_npc    = pc_q;
        end
      endcase
    end
    // drop writes to x0 and clear the reported fields
    if (rd == '0 || !ex_wr) begin
      ex_wr   = 1'b0;
      ex_load = LD_NONE;
      ex_val  = '0;
      ex_rd   = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // data memory: four byte banks, bank j holds addresses with low bits j
  for (genvar j = 0; j < NBANK; j++) begin : g_bank
    logic [7:0]       mem [ROWS];
    logic [7:0]       rdata_q;
    logic [1:0]       lane;
    logic [ROW_W-1:0] row;
    logic             we;
    logic [7:0]       wdata;

    // byte lane of the access that lands in this bank
    assign lane  = 2'(j) - ea_off;
    assign row   = clr_busy_q ? clr_row_q
                 : ((2'(j) >= ea_off) ? ea_row : ea_row + ROW_W'(1));
    assign we    = clr_busy_q ||
                   (ex_adv && (st_word || (st_byte && ea_off == 2'(j))));
    assign wdata = clr_busy_q ? 8'h00 : b[8*lane +: 8];

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[row] <= wdata;
      end
      if (ex_adv) begin
        rdata_q <= mem[row];
      end
    end

    assign dm_rdata[j] = rdata_q;
  end

  // ---------------------------------------------------------------------------
  // WB / result register
  always_ff @(posedge clk_i) begin
    if (ex_adv) begin
      wb_npc_q    <= ex_npc;
      wb_alu_q    <= ex_val;
      wb_taken_q  <= ex_taken;
      wb_wr_q     <= ex_wr;
      wb_rd_q     <= ex_rd;
      wb_status_q <= ex_status;
      wb_load_q   <= ex_load;
      wb_off_q    <= ea_off;
    end
  end

  always_comb begin
    unique case (wb_load_q)
      LD_BYTE: wb_value = {{24{dm_rdata[wb_off_q][7]}}, dm_rdata[wb_off_q]};
      LD_WORD: wb_value = {dm_rdata[wb_off_q + 2'd3], dm_rdata[wb_off_q + 2'd2],
                           dm_rdata[wb_off_q + 2'd1], dm_rdata[wb_off_q]};
      default: wb_value = wb_alu_q;
    endcase
  end

  assign out_o.valid           = wb_valid_q;
  assign out_o.next_pc         = wb_npc_q;
  assign out_o.branch_taken    = wb_taken_q;
  assign out_o.writes_register = wb_wr_q;
  assign out_o.dest_register   = wb_rd_q;
  assign out_o.write_value     = wb_value;
  assign out_o.status          = wb_status_q;

endmodule

`default_nettype wire

@@ rtl/rvc_checker.sv @@
// Port-level checks for rv32i_subset_core_step, attached by bind.
// Depends on rvc_pkg for status codes.
`default_nettype none

module rvc_checker import rvc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [XLEN-1:0]  out_next_pc_i,
  input wire logic             out_branch_taken_i,
  input wire logic             out_writes_register_i,
  input wire logic [1:0]       out_status_i
);

  logic            in_acc, out_acc;
  logic [1:0]      pend_q;
  logic [XLEN-1:0] last_npc_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // track beats in flight and the PC the last result left behind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      last_npc_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        last_npc_q <= out_next_pc_i;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat withdrawn before it was taken");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result beat without an instruction beat");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more instructions in flight than pipeline stages");

  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_status_i != ST_EXEC |->
      out_next_pc_i == last_npc_q && !out_writes_register_i && !out_branch_taken_i)
    else $error("end or illegal instruction changed state");

endmodule

bind rv32i_subset_core_step rvc_checker u_rvc_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .out_next_pc_i         (out_o.next_pc),
  .out_branch_taken_i    (out_o.branch_taken),
  .out_writes_register_i (out_o.writes_register),
  .out_status_i          (out_o.status)
);

`default_nettype wire

@@ tb/sv/rv32i_subset_core_step_tb.sv @@
// Self-checking bench for rv32i_subset_core_step: directed and random instruction beats
// checked against an architectural predictor of PC, registers and data memory.
// Depends on rvc_pkg, the rvc_in_if/rvc_out_if interfaces and the core itself.

module rv32i_subset_core_step_tb;
  import rvc_pkg::*;

  localparam int unsigned DATA_BYTES      = DEF_DATA_BYTES;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned HOLD_CYCLES     = 150;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [XLEN-1:0]  next_pc;
    logic             branch_taken;
    logic             writes_register;
    logic [REG_W-1:0] dest_register;
    logic [XLEN-1:0]  write_value;
    status_e          status;
  } step_result_t;

  class core_scoreboard;
    logic [XLEN-1:0] arch_pc;
    logic [XLEN-1:0] arch_regs [32];
    logic [7:0]      data_bytes [DATA_BYTES];
    step_result_t    pending_steps [$];
    int unsigned     mismatches;

    function new();
      arch_pc = '0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      foreach (data_bytes[i]) data_bytes[i] = '0;
      mismatches = 0;
    endfunction

    // Execute one accepted instruction on the architectural state and queue its result.
    function void note_instruction(logic [31:0] w);
      logic [6:0]      opc;
      logic [4:0]      rd;
      logic [2:0]      f3;
      logic [6:0]      f7;
      logic [XLEN-1:0] a, b, imm_i, imm_s, imm_b, imm_j, ea, npc, val;
      logic            wr, taken;
      status_e         st;
      step_result_t    res;
      opc   = w[6:0];
      rd    = w[11:7];
      f3    = w[14:12];
      f7    = w[31:25];
      a     = arch_regs[w[19:15]];
      b     = arch_regs[w[24:20]];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      npc   = arch_pc + 32'd4;
      val   = '0;
      wr    = 1'b0;
      taken = 1'b0;
      st    = ST_EXEC;
      if (w == '0) begin
        st  = ST_END;
        npc = arch_pc;
      end else begin
        case (opc)
          OP_R: begin
            if (f7 == F7_BASE && f3 == F3_ADD) begin
              val = a + b;
              wr  = 1'b1;
            end else if (f7 == F7_BASE && f3 == F3_XOR) begin
              val = a ^ b;
              wr  = 1'b1;
            end
          end
          OP_I: begin
            case (f3)
              F3_ADD: begin
                val = a + imm_i;
                wr  = 1'b1;
              end
              F3_ORI: begin
                val = a | imm_i;
                wr  = 1'b1;
              end
              F3_SRAI: begin
                val = $signed(a) >>> w[24:20];
                wr  = 1'b1;
              end
              default: ;
            endcase
          end
          OP_LOAD: begin
            ea = a + imm_i;
            if (f3 == F3_BYTE) begin
              val = {{24{data_bytes[ea % DATA_BYTES][7]}}, data_bytes[ea % DATA_BYTES]};
              wr  = 1'b1;
            end else if (f3 == F3_WORD) begin
              for (int k = 0; k < 4; k++) val[8*k +: 8] = data_bytes[(ea + k) % DATA_BYTES];
              wr = 1'b1;
            end
          end
          OP_STORE: begin
            ea = a + imm_s;
            if (f3 == F3_BYTE) begin
              data_bytes[ea % DATA_BYTES] = b[7:0];
            end else if (f3 == F3_WORD) begin
              for (int k = 0; k < 4; k++) data_bytes[(ea + k) % DATA_BYTES] = b[8*k +: 8];
            end
          end
          OP_BR: begin
            if (f3 == F3_BEQ && a == b) begin
              npc   = arch_pc + imm_b;
              taken = 1'b1;
            end
          end
          OP_JAL: begin
            val   = arch_pc + 32'd4;
            wr    = 1'b1;
            npc   = arch_pc + imm_j;
            taken = 1'b1;
          end
          OP_LUI: begin
            val = w & LUI_MASK;
            wr  = 1'b1;
          end
          default: begin
            st  = ST_ILLEGAL;
            npc = arch_pc;
          end
        endcase
      end
      // x0 stays zero: drop the write and report nothing
      if (rd == '0) wr = 1'b0;
      if (wr) begin
        arch_regs[rd] = val;
      end else begin
        val = '0;
        rd  = '0;
      end
      arch_pc             = npc;
      res.next_pc         = npc;
      res.branch_taken    = taken;
      res.writes_register = wr;
      res.dest_register   = rd;
      res.write_value     = val;
      res.status          = st;
      pending_steps.push_back(res);
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (pending_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: pc=%h taken=%b wr=%b rd=%0d val=%h st=%0d",
                   got.next_pc, got.branch_taken, got.writes_register,
                   got.dest_register, got.write_value, got.status);
        return;
      end
      want = pending_steps.pop_front();
      if (got.next_pc !== want.next_pc || got.branch_taken !== want.branch_taken ||
          got.writes_register !== want.writes_register ||
          got.dest_register !== want.dest_register ||
          got.write_value !== want.write_value || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result mismatch at %0t", $time);
          $display("  expected pc=%h taken=%b wr=%b rd=%0d val=%h st=%0d",
                   want.next_pc, want.branch_taken, want.writes_register,
                   want.dest_register, want.write_value, want.status);
          $display("  actual   pc=%h taken=%b wr=%b rd=%0d val=%h st=%0d",
                   got.next_pc, got.branch_taken, got.writes_register,
                   got.dest_register, got.write_value, got.status);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rvc_in_if  in_if();
  rvc_out_if out_if();

  rv32i_subset_core_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  core_scoreboard  sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     hold_requests = 0;
  int unsigned     hold_served   = 0;
  int unsigned     hold_left     = 0;
  int unsigned     cycle_count   = 0;
  logic [4:0]      store_base    = '0;
  logic [11:0]     store_imm     = '0;
  logic [31:0]     directed_words [$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_R};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BR};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
    return {imm, rd, OP_LUI};
  endfunction

  // Favor x0..x7 so results feed later operands.
  function automatic logic [4:0] random_reg();
    return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
  endfunction

  function automatic logic [2:0] random_mem_width(logic [2:0] raw);
    return ($urandom_range(7) == 0) ? raw : ($urandom_range(1) ? F3_BYTE : F3_WORD);
  endfunction

  function automatic logic [31:0] random_instruction();
    int unsigned pick;
    logic [4:0]  rd, rs1, rs2;
    logic [11:0] imm;
    logic [2:0]  f3;
    pick = $urandom_range(99);
    rd   = random_reg();
    rs1  = random_reg();
    rs2  = random_reg();
    imm  = 12'($urandom);
    f3   = 3'($urandom);
    if (pick < 14) begin
      if ($urandom_range(7) == 0) return enc_r(7'($urandom), rs2, rs1, f3, rd);
      return enc_r(F7_BASE, rs2, rs1, $urandom_range(1) ? F3_ADD : F3_XOR, rd);
    end
    if (pick < 34) begin
      case ($urandom_range(7))
        0:       ;
        1, 2, 3: f3 = F3_ADD;
        4, 5:    f3 = F3_ORI;
        default: f3 = F3_SRAI;
      endcase
      return enc_i(imm, rs1, f3, rd, OP_I);
    end
    if (pick < 50) begin
      store_base = rs1;
      store_imm  = imm;
      return enc_s(imm, rs2, rs1, random_mem_width(f3));
    end
    if (pick < 66) begin
      // revisit the last store address half the time
      if ($urandom_range(1)) begin
        rs1 = store_base;
        imm = store_imm;
      end
      return enc_i(imm, rs1, random_mem_width(f3), rd, OP_LOAD);
    end
    if (pick < 76) begin
      if ($urandom_range(2) == 0) rs2 = rs1;
      return enc_b(13'($urandom), rs2, rs1, ($urandom_range(7) == 0) ? f3 : F3_BEQ);
    end
    if (pick < 84) return enc_j(21'($urandom), rd);
    if (pick < 91) return enc_u(20'($urandom), rd);
    if (pick < 93) return '0;
    if (pick < 96) return {25'($urandom), 7'($urandom)};
    return $urandom;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_instruction(logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.instruction_word <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_instruction(w);
    @(negedge clk_i);
  endtask

  // Result-side backpressure, with one long hold-off requested at the start of the first random phase.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served  <= hold_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result('{next_pc:         out_if.next_pc,
                        branch_taken:    out_if.branch_taken,
                        writes_register: out_if.writes_register,
                        dest_register:   out_if.dest_register,
                        write_value:     out_if.write_value,
                        status:          status_e'(out_if.status)});
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.instruction_word = '0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    sb                     = new();

    // end word, all-ones, opcode zero with upper bits set
    directed_words.push_back('0);
    directed_words.push_back(32'hFFFF_FFFF);
    directed_words.push_back(32'h0000_0080);
    // register extremes and every ALU operation
    directed_words.push_back(enc_u(20'hFFFFF, 5'd1));
    directed_words.push_back(enc_i(12'h800, 5'd0, F3_ADD, 5'd2, OP_I));
    directed_words.push_back(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OP_I));
    directed_words.push_back(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd4));
    directed_words.push_back(enc_r(F7_BASE, 5'd3, 5'd1, F3_XOR, 5'd5));
    directed_words.push_back(enc_i(12'h800, 5'd3, F3_ORI, 5'd6, OP_I));
    directed_words.push_back(enc_i({7'h20, 5'd31}, 5'd1, F3_SRAI, 5'd7, OP_I));
    directed_words.push_back(enc_i({7'h7F, 5'd0}, 5'd1, F3_SRAI, 5'd8, OP_I));
    // write to x0, unsupported funct codes
    directed_words.push_back(enc_r(F7_BASE, 5'd3, 5'd1, F3_ADD, 5'd0));
    directed_words.push_back(enc_r(7'h20, 5'd3, 5'd1, F3_ADD, 5'd9));
    directed_words.push_back(enc_r(F7_BASE, 5'd3, 5'd1, 3'd1, 5'd9));
    directed_words.push_back(enc_i(12'h001, 5'd1, 3'd1, 5'd9, OP_I));
    // memory: negative address, word wrapping past the top, byte sign extension
    directed_words.push_back(enc_s(12'hFFC, 5'd1, 5'd0, F3_WORD));
    directed_words.push_back(enc_s(12'h7FF, 5'd5, 5'd3, F3_WORD));
    directed_words.push_back(enc_i(12'h7FF, 5'd3, F3_WORD, 5'd10, OP_LOAD));
    directed_words.push_back(enc_i(12'hFFF, 5'd0, F3_BYTE, 5'd11, OP_LOAD));
    directed_words.push_back(enc_s(12'h000, 5'd3, 5'd2, F3_BYTE));
    directed_words.push_back(enc_i(12'h000, 5'd2, F3_BYTE, 5'd12, OP_LOAD));
    directed_words.push_back(enc_i(12'h000, 5'd0, 3'd1, 5'd13, OP_LOAD));
    directed_words.push_back(enc_s(12'h000, 5'd1, 5'd0, 3'd1));
    // control flow: taken, not taken, bad funct3, jal at both offset extremes
    directed_words.push_back(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));
    directed_words.push_back(enc_b(13'h0FFE, 5'd0, 5'd1, F3_BEQ));
    directed_words.push_back(enc_b(13'h0010, 5'd0, 5'd0, 3'd1));
    directed_words.push_back(enc_j(21'h100000, 5'd13));
    directed_words.push_back(enc_j(21'h0FFFFE, 5'd0));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_words[i]) send_instruction(directed_words[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_requests++;
        end
        1: begin
          send_idle_pct  = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_instruction(random_instruction());
    end
    in_if.valid <= 1'b0;

    while (sb.pending_steps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_steps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rvc_pkg.sv
rtl/rvc_if.sv
rtl/rv32i_subset_core_step.sv
rtl/rvc_checker.sv
tb/sv/rv32i_subset_core_step_tb.sv
